// ----- rtl/core/rcsfp_pkg.sv -----
`timescale 1ns / 1ps

package rcsfp_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned SERVO_WORDS = 7;

  localparam int unsigned FillW  = $clog2(FRAME_BYTES);
  localparam int unsigned SlotW  = (SERVO_WORDS > 1) ? $clog2(SERVO_WORDS) : 1;
  localparam int unsigned WordBytes = 2 + 2 * SERVO_WORDS;
  localparam int unsigned ExtBytes  = (FRAME_BYTES > WordBytes) ? FRAME_BYTES : WordBytes;

  // Known system codes.
  localparam logic [7:0] SysDsm2_1024 = 8'h01;
  localparam logic [7:0] SysDsm2_2048 = 8'h12;
  localparam logic [7:0] SysDsmx_22ms = 8'hA2;
  localparam logic [7:0] SysDsmx_11ms = 8'hB2;

  localparam logic [15:0] DropMax = 16'hFFFF;

  function automatic logic code_known(input logic [7:0] code);
    return (code == SysDsm2_1024) || (code == SysDsm2_2048) ||
           (code == SysDsmx_22ms) || (code == SysDsmx_11ms);
  endfunction

endpackage

// ----- rtl/core/rc_serial_frame_parser.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       to block   in_valid_i / in_stall_o  rx_byte_i
// out      from block out_valid_o / out_stall_i fade_count_o, system_code_o, word_slot_o,
//                                              channel_number_o, servo_value_o, phase_bit_o,
//                                              last_word_o, dropped_total_o
//
// One byte is taken per cycle. The byte that completes a frame loads a word buffer, and the
// burst of servo words then leaves one per cycle from that buffer while out_stall_i is low, as
// new bytes keep arriving. The input stalls only when the closing byte of the next frame arrives
// before the burst of the previous frame has fully drained. Reset clears the fill count, the drop
// counter and the output burst; the frame byte store is not cleared.
module rc_serial_frame_parser
  import rcsfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  fade_count_o,
  output logic [7:0]  system_code_o,
  output logic [2:0]  word_slot_o,
  output logic [5:0]  channel_number_o,
  output logic [10:0] servo_value_o,
  output logic        phase_bit_o,
  output logic        last_word_o,
  output logic [15:0] dropped_total_o
);

  logic [7:0]       frame_q [FRAME_BYTES];
  logic [FillW-1:0] fill_q, fill_d;
  logic [15:0]      drop_q, drop_d;

  logic [15:0]      words_q [SERVO_WORDS];
  logic [7:0]       fade_q;
  logic [7:0]       sys_q;
  logic [15:0]      drop_snap_q;
  logic [SlotW-1:0] slot_q;
  logic             busy_q;

  logic       in_fire, out_fire, frame_done, last_slot;
  logic [7:0] cur_bytes [FRAME_BYTES];
  logic [7:0] ext_bytes [ExtBytes];
  logic       bad_code;

  assign last_slot  = (slot_q == SlotW'(SERVO_WORDS - 1));
  assign in_stall_o = busy_q && (fill_q == FillW'(FRAME_BYTES - 1));
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = busy_q && !out_stall_i;
  assign frame_done = in_fire && (fill_q == FillW'(FRAME_BYTES - 1));
  assign bad_code   = !code_known(rx_byte_i);

  // Frame as it stands with the incoming byte in place; bytes past the frame read as zero.
  always_comb begin
    for (int j = 0; j < FRAME_BYTES; j++) begin
      cur_bytes[j] = (fill_q == FillW'(j)) ? rx_byte_i : frame_q[j];
    end
    for (int k = 0; k < ExtBytes; k++) begin
      ext_bytes[k] = 8'h00;
    end
    for (int k = 0; k < FRAME_BYTES; k++) begin
      ext_bytes[k] = cur_bytes[k];
    end
  end

  always_comb begin
    fill_d = fill_q;
    drop_d = drop_q;
    if (in_fire) begin
      if (fill_q == FillW'(1)) begin
        if (bad_code) begin
          // Slide by one byte: the system byte becomes the new fades byte.
          if (drop_q != DropMax) begin
            drop_d = drop_q + 16'd1;
          end
        end else begin
          fill_d = FillW'(2);
        end
      end else if (frame_done) begin
        fill_d = '0;
      end else begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (fill_q == FillW'(1) && bad_code) begin
        frame_q[0] <= rx_byte_i;
      end else begin
        frame_q[fill_q] <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      drop_q <= '0;
      busy_q <= 1'b0;
      slot_q <= '0;
    end else begin
      fill_q <= fill_d;
      drop_q <= drop_d;
      if (frame_done) begin
        busy_q <= 1'b1;
        slot_q <= '0;
      end else if (out_fire) begin
        if (last_slot) begin
          busy_q <= 1'b0;
        end else begin
          slot_q <= slot_q + SlotW'(1);
        end
      end
    end
  end

  // Word buffer: loaded at frame completion, shifted one word per delivered item.
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      fade_q      <= cur_bytes[0];
      sys_q       <= cur_bytes[1];
      drop_snap_q <= drop_q;
      for (int i = 0; i < SERVO_WORDS; i++) begin
        words_q[i] <= {ext_bytes[2 + 2 * i], ext_bytes[3 + 2 * i]};
      end
    end else if (out_fire) begin
      for (int i = 0; i < SERVO_WORDS - 1; i++) begin
        words_q[i] <= words_q[i + 1];
      end
    end
  end

  always_comb begin
    if (sys_q == SysDsm2_1024) begin
      phase_bit_o      = 1'b0;
      channel_number_o = words_q[0][15:10];
      servo_value_o    = {1'b0, words_q[0][9:0]};
    end else begin
      phase_bit_o      = words_q[0][15];
      channel_number_o = {2'b00, words_q[0][14:11]};
      servo_value_o    = words_q[0][10:0];
    end
  end

  assign out_valid_o     = busy_q;
  assign fade_count_o    = fade_q;
  assign system_code_o   = sys_q;
  assign word_slot_o     = 3'(slot_q);
  assign last_word_o     = last_slot;
  assign dropped_total_o = drop_snap_q;

`ifndef SYNTHESIS
  a_stall_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending burst");

  a_burst_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_word_o |=> !out_valid_o)
    else $error("burst continued past its last word");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o)
    else $error("burst ended before its last word");

  a_drop_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q >= $past(drop_q))
    else $error("drop counter decreased");
`endif

endmodule
